// File: sv/bowrq_pkg.sv
`default_nettype none
package bowrq_pkg;

    localparam int MAX_SLOTS           = 64;
    localparam int MAX_BATCH           = 64;
    localparam int MAX_FRAMES_PER_ITEM = 64;

    localparam int OP_W     = 2;
    localparam int CNT_W    = 7;
    localparam int CFG_W    = 7;
    localparam int IDX_W    = 2;
    localparam int SLOT_W   = 6;
    localparam int FILL_W   = 6;
    localparam int ADDR_W   = 12;
    localparam int HELD_W   = 7;
    localparam int FRAMES_W = 13;
    localparam int KIND_W   = 2;

    localparam logic [OP_W-1:0] OP_ENQ   = 2'd0;
    localparam logic [OP_W-1:0] OP_DEQ   = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

    localparam logic [KIND_W-1:0] KIND_WRITE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_READ  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_EMPTY = 2'd2;
    localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd3;

    localparam logic [IDX_W-1:0] CFG_BATCH_FRAMES = 2'd0;
    localparam logic [IDX_W-1:0] CFG_SLOT_COUNT   = 2'd1;

    typedef struct packed {
        logic cfg_write;
        logic load;
        logic step;
    } cmd_t;

    typedef struct packed {
        logic has_result;
        logic step_last;
    } status_t;

endpackage
`default_nettype wire

// File: sv/bowrq_ctrl.sv
`default_nettype none
module bowrq_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    output logic                   out_valid,
    input  wire logic              out_stall,
    input  wire bowrq_pkg::status_t status,
    output bowrq_pkg::cmd_t        cmd
);
    import bowrq_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EXEC = 2'b10
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   can_load;

    assign can_load  = !out_valid_reg || !out_stall;
    assign in_stall  = (state_reg != ST_IDLE);
    // an input beat takes the idle slot first
    assign cfg_ready = (state_reg == ST_IDLE) && !in_valid;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && out_stall;
        cmd            = '0;
        cmd.cfg_write  = cfg_valid && cfg_ready;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    if (status.has_result)
                    begin
                        state_next = ST_EXEC;
                    end
                end
            end
            ST_EXEC:
            begin
                if (can_load)
                begin
                    cmd.step       = 1'b1;
                    out_valid_next = 1'b1;
                    if (status.step_last)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule
`default_nettype wire

// File: sv/bowrq_dp.sv
`default_nettype none
module bowrq_dp (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire bowrq_pkg::cmd_t                    cmd,
    output bowrq_pkg::status_t                      status,
    input  wire logic [bowrq_pkg::IDX_W-1:0]        cfg_index,
    input  wire logic [bowrq_pkg::CFG_W-1:0]        cfg_data,
    input  wire logic [bowrq_pkg::OP_W-1:0]         op,
    input  wire logic [bowrq_pkg::CNT_W-1:0]        frame_count,
    output logic [bowrq_pkg::KIND_W-1:0]            kind,
    output logic [bowrq_pkg::ADDR_W-1:0]            frame_address,
    output logic [bowrq_pkg::CNT_W-1:0]             chunk_length,
    output logic                                    batch_closed,
    output logic                                    overwrote_oldest,
    output logic [bowrq_pkg::HELD_W-1:0]            batches_held,
    output logic [bowrq_pkg::FRAMES_W-1:0]          frames_held,
    output logic                                    overwrite_seen,
    output logic                                    open_batch_empty,
    output logic                                    last
);
    import bowrq_pkg::*;

    localparam logic [CFG_W-1:0] BATCH_MAX = CFG_W'(MAX_BATCH);
    localparam logic [CFG_W-1:0] SLOTS_MAX = CFG_W'(MAX_SLOTS);
    localparam logic [CNT_W-1:0] FRAMES_MAX = CNT_W'(MAX_FRAMES_PER_ITEM);

    logic [CFG_W-1:0]    batch_frames_reg, batch_frames_next;
    logic [CFG_W-1:0]    slot_count_reg, slot_count_next;
    logic [FILL_W-1:0]   open_fill_reg, open_fill_next;
    logic [SLOT_W-1:0]   write_slot_reg, write_slot_next;
    logic [SLOT_W-1:0]   read_slot_reg, read_slot_next;
    logic [HELD_W-1:0]   held_batches_reg, held_batches_next;
    logic [FRAMES_W-1:0] held_frames_reg, held_frames_next;
    logic                overwrite_reg, overwrite_next;
    logic [OP_W-1:0]     op_reg, op_next;
    logic [CNT_W-1:0]    left_reg, left_next;

    logic [KIND_W-1:0]   res_kind;
    logic [ADDR_W-1:0]   res_addr;
    logic [CNT_W-1:0]    res_len;
    logic                res_closed;
    logic                res_dropped;

    logic [CNT_W-1:0]    room;
    logic [CNT_W-1:0]    len;
    logic [CNT_W-1:0]    fill_sum;
    logic [SLOT_W-1:0]   slot_sel;
    logic [FRAMES_W-1:0] prod;
    logic [FRAMES_W-1:0] addr_full;
    logic [CNT_W-1:0]    ws_inc;
    logic [CNT_W-1:0]    rs_inc;
    logic [SLOT_W-1:0]   ws_wrap;
    logic [SLOT_W-1:0]   rs_wrap;
    logic [CFG_W-1:0]    cfg_sat;
    logic [CFG_W-1:0]    cfg_max;
    logic [CNT_W-1:0]    fc_sat;

    assign room     = batch_frames_reg - {1'b0, open_fill_reg};
    assign len      = (left_reg < room) ? left_reg : room;
    assign fill_sum = {1'b0, open_fill_reg} + len;
    assign slot_sel = (op_reg == OP_ENQ) ? write_slot_reg : read_slot_reg;
    assign prod     = {7'd0, slot_sel} * {6'd0, batch_frames_reg};
    assign addr_full = (op_reg == OP_ENQ) ? prod + {7'd0, open_fill_reg} : prod;
    assign ws_inc   = {1'b0, write_slot_reg} + 7'd1;
    assign rs_inc   = {1'b0, read_slot_reg} + 7'd1;
    assign ws_wrap  = (ws_inc >= slot_count_reg) ? '0 : ws_inc[SLOT_W-1:0];
    assign rs_wrap  = (rs_inc >= slot_count_reg) ? '0 : rs_inc[SLOT_W-1:0];
    assign cfg_max  = (cfg_index == CFG_BATCH_FRAMES) ? BATCH_MAX : SLOTS_MAX;
    assign cfg_sat  = (cfg_data == '0) ? 7'd1 : ((cfg_data > cfg_max) ? cfg_max : cfg_data);
    assign fc_sat   = (frame_count > FRAMES_MAX) ? FRAMES_MAX : frame_count;

    assign status.has_result = (op == OP_DEQ) || (op == OP_CLEAR) ||
                               ((op == OP_ENQ) && (frame_count != '0));
    assign status.step_last  = (op_reg != OP_ENQ) || (left_reg <= room);

    always_comb
    begin
        batch_frames_next = batch_frames_reg;
        slot_count_next   = slot_count_reg;
        open_fill_next    = open_fill_reg;
        write_slot_next   = write_slot_reg;
        read_slot_next    = read_slot_reg;
        held_batches_next = held_batches_reg;
        held_frames_next  = held_frames_reg;
        overwrite_next    = overwrite_reg;
        op_next           = op_reg;
        left_next         = left_reg;
        res_kind          = KIND_WRITE;
        res_addr          = '0;
        res_len           = '0;
        res_closed        = 1'b0;
        res_dropped       = 1'b0;

        if (cmd.cfg_write)
        begin
            if (cfg_index == CFG_BATCH_FRAMES || cfg_index == CFG_SLOT_COUNT)
            begin
                if (cfg_index == CFG_BATCH_FRAMES)
                begin
                    batch_frames_next = cfg_sat;
                end
                else
                begin
                    slot_count_next = cfg_sat;
                end
                open_fill_next    = '0;
                write_slot_next   = '0;
                read_slot_next    = '0;
                held_batches_next = '0;
                held_frames_next  = '0;
                overwrite_next    = 1'b0;
            end
        end
        else if (cmd.load)
        begin
            op_next   = op;
            left_next = fc_sat;
        end
        else if (cmd.step)
        begin
            case (op_reg)
                OP_ENQ:
                begin
                    res_kind       = KIND_WRITE;
                    res_addr       = addr_full[ADDR_W-1:0];
                    res_len        = len;
                    left_next      = left_reg - len;
                    open_fill_next = fill_sum[FILL_W-1:0];
                    if (fill_sum >= batch_frames_reg)
                    begin
                        res_closed      = 1'b1;
                        open_fill_next  = '0;
                        write_slot_next = ws_wrap;
                        if (held_batches_reg >= slot_count_reg)
                        begin
                            res_dropped    = 1'b1;
                            overwrite_next = 1'b1;
                            read_slot_next = rs_wrap;
                        end
                        else
                        begin
                            held_batches_next = held_batches_reg + 7'd1;
                            held_frames_next  = held_frames_reg + {6'd0, batch_frames_reg};
                        end
                    end
                end
                OP_DEQ:
                begin
                    if (held_batches_reg != '0)
                    begin
                        res_kind          = KIND_READ;
                        res_addr          = addr_full[ADDR_W-1:0];
                        res_len           = batch_frames_reg;
                        read_slot_next    = rs_wrap;
                        held_batches_next = held_batches_reg - 7'd1;
                        held_frames_next  = (held_frames_reg >= {6'd0, batch_frames_reg}) ?
                                            held_frames_reg - {6'd0, batch_frames_reg} : '0;
                    end
                    else
                    begin
                        res_kind = KIND_EMPTY;
                    end
                end
                OP_CLEAR:
                begin
                    res_kind          = KIND_CLEAR;
                    open_fill_next    = '0;
                    write_slot_next   = '0;
                    read_slot_next    = '0;
                    held_batches_next = '0;
                    held_frames_next  = '0;
                    overwrite_next    = 1'b0;
                end
                default:
                begin
                    res_kind = KIND_CLEAR;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            batch_frames_reg <= 7'd1;
            slot_count_reg   <= SLOTS_MAX;
            open_fill_reg    <= '0;
            write_slot_reg   <= '0;
            read_slot_reg    <= '0;
            held_batches_reg <= '0;
            held_frames_reg  <= '0;
            overwrite_reg    <= 1'b0;
            op_reg           <= OP_ENQ;
            left_reg         <= '0;
        end
        else
        begin
            batch_frames_reg <= batch_frames_next;
            slot_count_reg   <= slot_count_next;
            open_fill_reg    <= open_fill_next;
            write_slot_reg   <= write_slot_next;
            read_slot_reg    <= read_slot_next;
            held_batches_reg <= held_batches_next;
            held_frames_reg  <= held_frames_next;
            overwrite_reg    <= overwrite_next;
            op_reg           <= op_next;
            left_reg         <= left_next;
        end
    end

    // result beat register
    always_ff @(posedge clk)
    begin
        if (cmd.step)
        begin
            kind             <= res_kind;
            frame_address    <= res_addr;
            chunk_length     <= res_len;
            batch_closed     <= res_closed;
            overwrote_oldest <= res_dropped;
            batches_held     <= held_batches_next;
            frames_held      <= held_frames_next;
            overwrite_seen   <= overwrite_next;
            open_batch_empty <= (open_fill_next == '0);
            last             <= status.step_last;
        end
    end

endmodule
`default_nettype wire

// File: sv/batched_overwrite_ring_queue.sv
// An input beat loads the op and frame count registers in ST_IDLE; ST_EXEC then steps and
// registers each result beat, giving enqueue one chunk per cycle while out_stall is low.
// in_stall holds new items off until ST_EXEC ends; chunk steps go through one slot multiplier.
// Enqueue of zero frames and unused op codes are taken in ST_IDLE and give no result.
// Reset (rst_n low, async): queue empty, batch length 1, slot_count 64, no beat pending.
`default_nettype none
module batched_overwrite_ring_queue (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               in_valid,
    output logic                                    in_stall,
    input  wire logic [bowrq_pkg::OP_W-1:0]         op,
    input  wire logic [bowrq_pkg::CNT_W-1:0]        frame_count,
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [bowrq_pkg::IDX_W-1:0]        cfg_index,
    input  wire logic [bowrq_pkg::CFG_W-1:0]        cfg_data,
    output logic                                    out_valid,
    input  wire logic                               out_stall,
    output logic [bowrq_pkg::KIND_W-1:0]            kind,
    output logic [bowrq_pkg::ADDR_W-1:0]            frame_address,
    output logic [bowrq_pkg::CNT_W-1:0]             chunk_length,
    output logic                                    batch_closed,
    output logic                                    overwrote_oldest,
    output logic [bowrq_pkg::HELD_W-1:0]            batches_held,
    output logic [bowrq_pkg::FRAMES_W-1:0]          frames_held,
    output logic                                    overwrite_seen,
    output logic                                    open_batch_empty,
    output logic                                    last
);
    import bowrq_pkg::*;

    cmd_t    cmd;
    status_t status;

    bowrq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    bowrq_dp u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .status           (status),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .op               (op),
        .frame_count      (frame_count),
        .kind             (kind),
        .frame_address    (frame_address),
        .chunk_length     (chunk_length),
        .batch_closed     (batch_closed),
        .overwrote_oldest (overwrote_oldest),
        .batches_held     (batches_held),
        .frames_held      (frames_held),
        .overwrite_seen   (overwrite_seen),
        .open_batch_empty (open_batch_empty),
        .last             (last)
    );

`ifndef ASSERT_OFF
    a_write_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && kind == KIND_WRITE) |-> (chunk_length != '0))
        else $error("write beat with zero length");

    a_close_empties: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && kind == KIND_WRITE && batch_closed) |-> open_batch_empty)
        else $error("closed batch left a partial fill");

    a_drop_flags: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && kind == KIND_WRITE && overwrote_oldest) |-> (batch_closed && overwrite_seen))
        else $error("overwrite without close or sticky flag");

    a_clear_state: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && kind == KIND_CLEAR) |->
        (last && batches_held == '0 && frames_held == '0 && !overwrite_seen && open_batch_empty))
        else $error("clear beat shows leftover state");
`endif

endmodule
`default_nettype wire

// File: dv/ring_queue_checker.sv
module ring_queue_checker (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    input  wire logic                           in_stall,
    input  wire logic [bowrq_pkg::OP_W-1:0]     op,
    input  wire logic [bowrq_pkg::CNT_W-1:0]    frame_count,
    input  wire logic                           cfg_valid,
    input  wire logic                           cfg_ready,
    input  wire logic [bowrq_pkg::IDX_W-1:0]    cfg_index,
    input  wire logic [bowrq_pkg::CFG_W-1:0]    cfg_data,
    input  wire logic                           out_valid,
    input  wire logic                           out_stall,
    input  wire logic [bowrq_pkg::KIND_W-1:0]   kind,
    input  wire logic [bowrq_pkg::ADDR_W-1:0]   frame_address,
    input  wire logic [bowrq_pkg::CNT_W-1:0]    chunk_length,
    input  wire logic                           batch_closed,
    input  wire logic                           overwrote_oldest,
    input  wire logic [bowrq_pkg::HELD_W-1:0]   batches_held,
    input  wire logic [bowrq_pkg::FRAMES_W-1:0] frames_held,
    input  wire logic                           overwrite_seen,
    input  wire logic                           open_batch_empty,
    input  wire logic                           last,
    output int                                  failures,
    output int                                  pending
);
    import bowrq_pkg::*;

    typedef struct packed {
        logic [KIND_W-1:0]   kind;
        logic [ADDR_W-1:0]   addr;
        logic [CNT_W-1:0]    len;
        logic                closed;
        logic                dropped;
        logic [HELD_W-1:0]   batches;
        logic [FRAMES_W-1:0] frames;
        logic                seen;
        logic                open_empty;
        logic                last;
    } ring_beat_t;

    ring_beat_t owed_beats[$];

    logic [CFG_W-1:0]    batch_frames_q;
    logic [CFG_W-1:0]    slot_count_q;
    logic [FILL_W-1:0]   fill_q;
    logic [SLOT_W-1:0]   wr_slot_q;
    logic [SLOT_W-1:0]   rd_slot_q;
    logic [HELD_W-1:0]   held_b_q;
    logic [FRAMES_W-1:0] held_f_q;
    logic                ovf_q;
    int                  mismatches = 0;

    assign failures = mismatches;
    assign pending  = owed_beats.size();

    task automatic empty_ring();
        fill_q    = '0;
        wr_slot_q = '0;
        rd_slot_q = '0;
        held_b_q  = '0;
        held_f_q  = '0;
        ovf_q     = 1'b0;
    endtask

    function automatic ring_beat_t snapshot(input logic [KIND_W-1:0] k,
                                            input logic [ADDR_W-1:0] a,
                                            input logic [CNT_W-1:0] n,
                                            input logic c, input logic d,
                                            input logic l);
        ring_beat_t r;
        r.kind       = k;
        r.addr       = a;
        r.len        = n;
        r.closed     = c;
        r.dropped    = d;
        r.batches    = held_b_q;
        r.frames     = held_f_q;
        r.seen       = ovf_q;
        r.open_empty = (fill_q == 0);
        r.last       = l;
        return r;
    endfunction

    function automatic string show(input ring_beat_t r);
        return $sformatf({"kind=%0d addr=%0d len=%0d closed=%0b drop=%0b held=%0d ",
                          "frames=%0d ovf=%0b open_empty=%0b last=%0b"},
                         r.kind, r.addr, r.len, r.closed, r.dropped, r.batches,
                         r.frames, r.seen, r.open_empty, r.last);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        ring_beat_t       got;
        ring_beat_t       want;
        int               left;
        int               room;
        int               len;
        logic [ADDR_W-1:0] addr;
        logic             closed;
        logic             dropped;
        logic [CFG_W-1:0] v;

        if (!rst_n)
        begin
            batch_frames_q = CFG_W'(1);
            slot_count_q   = CFG_W'(MAX_SLOTS);
            empty_ring();
            owed_beats.delete();
        end
        else
        begin
            // result side first: a beat leaving now never stems from a beat entering now
            if (out_valid && !out_stall)
            begin
                got = {kind, frame_address, chunk_length, batch_closed, overwrote_oldest,
                       batches_held, frames_held, overwrite_seen, open_batch_empty, last};
                if (owed_beats.size() == 0)
                begin
                    if (mismatches < 10)
                        $display("%0t unexpected result beat: %s", $realtime, show(got));
                    mismatches++;
                end
                else
                begin
                    want = owed_beats.pop_front();
                    if (got !== want)
                    begin
                        if (mismatches < 10)
                        begin
                            $display("%0t result mismatch", $realtime);
                            $display("  expected %s", show(want));
                            $display("  actual   %s", show(got));
                        end
                        mismatches++;
                    end
                end
            end

            if (cfg_valid && cfg_ready)
            begin
                v = cfg_data;
                if (cfg_index == CFG_BATCH_FRAMES)
                begin
                    if (v < 1)
                        v = CFG_W'(1);
                    if (v > MAX_BATCH)
                        v = CFG_W'(MAX_BATCH);
                    batch_frames_q = v;
                    empty_ring();
                end
                else if (cfg_index == CFG_SLOT_COUNT)
                begin
                    if (v < 1)
                        v = CFG_W'(1);
                    if (v > MAX_SLOTS)
                        v = CFG_W'(MAX_SLOTS);
                    slot_count_q = v;
                    empty_ring();
                end
            end

            if (in_valid && !in_stall)
            begin
                case (op)
                    OP_ENQ:
                    begin
                        left = (frame_count > MAX_FRAMES_PER_ITEM) ? MAX_FRAMES_PER_ITEM
                                                                   : int'(frame_count);
                        while (left > 0)
                        begin
                            room    = int'(batch_frames_q) - int'(fill_q);
                            len     = (left < room) ? left : room;
                            addr    = ADDR_W'(int'(wr_slot_q) * int'(batch_frames_q)
                                              + int'(fill_q));
                            closed  = 1'b0;
                            dropped = 1'b0;
                            if (int'(fill_q) + len >= int'(batch_frames_q))
                            begin
                                closed    = 1'b1;
                                fill_q    = '0;
                                wr_slot_q = SLOT_W'((int'(wr_slot_q) + 1)
                                                    % int'(slot_count_q));
                                if (held_b_q >= slot_count_q)
                                begin
                                    dropped   = 1'b1;
                                    ovf_q     = 1'b1;
                                    rd_slot_q = SLOT_W'((int'(rd_slot_q) + 1)
                                                        % int'(slot_count_q));
                                end
                                else
                                begin
                                    held_b_q = held_b_q + HELD_W'(1);
                                    held_f_q = held_f_q + FRAMES_W'(batch_frames_q);
                                end
                            end
                            else
                                fill_q = FILL_W'(int'(fill_q) + len);
                            left -= len;
                            owed_beats.push_back(snapshot(KIND_WRITE, addr, CNT_W'(len),
                                                          closed, dropped, left == 0));
                        end
                    end
                    OP_DEQ:
                    begin
                        if (held_b_q > 0)
                        begin
                            addr      = ADDR_W'(int'(rd_slot_q) * int'(batch_frames_q));
                            rd_slot_q = SLOT_W'((int'(rd_slot_q) + 1) % int'(slot_count_q));
                            held_b_q  = held_b_q - HELD_W'(1);
                            held_f_q  = (held_f_q >= FRAMES_W'(batch_frames_q))
                                        ? held_f_q - FRAMES_W'(batch_frames_q) : '0;
                            owed_beats.push_back(snapshot(KIND_READ, addr, batch_frames_q,
                                                          1'b0, 1'b0, 1'b1));
                        end
                        else
                            owed_beats.push_back(snapshot(KIND_EMPTY, '0, '0,
                                                          1'b0, 1'b0, 1'b1));
                    end
                    OP_CLEAR:
                    begin
                        empty_ring();
                        owed_beats.push_back(snapshot(KIND_CLEAR, '0, '0, 1'b0, 1'b0, 1'b1));
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

endmodule

// File: dv/tb_top.sv
module tb_top;
    import bowrq_pkg::*;

    localparam logic [OP_W-1:0]  OP_UNUSED   = 2'd3;
    localparam logic [IDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [IDX_W-1:0] CFG_SPARE_B = 2'd3;
    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int HOLD_CYCLES   = 400;
    localparam int ITEMS_PER_SET = 38;
    localparam int N_SETS        = 8;
    localparam int CNT_MAX       = (1 << CNT_W) - 1;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_stall;
    logic [OP_W-1:0]     op = OP_ENQ;
    logic [CNT_W-1:0]    frame_count = '0;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [IDX_W-1:0]    cfg_index = CFG_BATCH_FRAMES;
    logic [CFG_W-1:0]    cfg_data = '0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    logic [KIND_W-1:0]   kind;
    logic [ADDR_W-1:0]   frame_address;
    logic [CNT_W-1:0]    chunk_length;
    logic                batch_closed;
    logic                overwrote_oldest;
    logic [HELD_W-1:0]   batches_held;
    logic [FRAMES_W-1:0] frames_held;
    logic                overwrite_seen;
    logic                open_batch_empty;
    logic                last;

    int failures;
    int pending;
    int cycle_count = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int cur_batch = 1;
    bit hold_go = 1'b0;
    bit hold_seen = 1'b0;
    int hold_left = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    batched_overwrite_ring_queue u_top (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .op               (op),
        .frame_count      (frame_count),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .kind             (kind),
        .frame_address    (frame_address),
        .chunk_length     (chunk_length),
        .batch_closed     (batch_closed),
        .overwrote_oldest (overwrote_oldest),
        .batches_held     (batches_held),
        .frames_held      (frames_held),
        .overwrite_seen   (overwrite_seen),
        .open_batch_empty (open_batch_empty),
        .last             (last)
    );

    ring_queue_checker u_check (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .op               (op),
        .frame_count      (frame_count),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .kind             (kind),
        .frame_address    (frame_address),
        .chunk_length     (chunk_length),
        .batch_closed     (batch_closed),
        .overwrote_oldest (overwrote_oldest),
        .batches_held     (batches_held),
        .frames_held      (frames_held),
        .overwrite_seen   (overwrite_seen),
        .open_batch_empty (open_batch_empty),
        .last             (last),
        .failures         (failures),
        .pending          (pending)
    );

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // result side: random stall, or a long hold-off when requested
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (hold_go != hold_seen)
            begin
                hold_seen = hold_go;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                out_stall = 1'b1;
                hold_left--;
            end
            else
                out_stall = ($urandom_range(99) < recv_stall_pct);
        end
    end

    task automatic offer(input logic [OP_W-1:0] o, input logic [CNT_W-1:0] n);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid    = 1'b1;
        op          = o;
        frame_count = n;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic drain();
        @(negedge clk);
        in_valid = 1'b0;
        while (pending != 0)
            @(negedge clk);
        // zero-count enqueues and unused ops give no beat but may still be in flight
        repeat (8) @(negedge clk);
    endtask

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        drain();
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid = 1'b0;
        if (idx == CFG_BATCH_FRAMES)
            cur_batch = (val == 0) ? 1 : (val > MAX_BATCH) ? MAX_BATCH : int'(val);
    endtask

    task automatic random_item(output bit counts);
        int               r;
        int               hi;
        logic [OP_W-1:0]  o;
        logic [CNT_W-1:0] n;

        r = $urandom_range(99);
        n = CNT_W'($urandom_range(CNT_MAX));
        if (r < 64)
            o = OP_ENQ;
        else if (r < 91)
            o = OP_DEQ;
        else if (r < 94)
            o = OP_CLEAR;
        else
            o = OP_UNUSED;
        if (o == OP_ENQ)
        begin
            r  = $urandom_range(99);
            hi = (2 * cur_batch + 1 > MAX_FRAMES_PER_ITEM) ? MAX_FRAMES_PER_ITEM
                                                           : 2 * cur_batch + 1;
            if (r < 5)
                n = '0;
            else if (r < 10)
                n = CNT_W'($urandom_range(CNT_MAX, MAX_FRAMES_PER_ITEM + 1));
            else if (r < 15)
                n = CNT_W'(MAX_FRAMES_PER_ITEM);
            else
                n = CNT_W'($urandom_range(hi, 1));
        end
        offer(o, n);
        counts = (o == OP_DEQ) || (o == OP_CLEAR) || (o == OP_ENQ && n != 0);
    endtask

    initial
    begin
        int batch_raw [N_SETS];
        int slot_raw  [N_SETS];
        int idle_tx   [4];
        int idle_rx   [4];
        int done;
        bit counted;

        batch_raw = '{0, 127, 4, 3, 64, 7, 2, 16};
        slot_raw  = '{1, 64, 2, 5, 100, 3, 0, 4};
        idle_tx   = '{0, 78, 0, 21};
        idle_rx   = '{0, 0, 78, 21};

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset config: one frame per batch, 64 slots
        offer(OP_DEQ, '0);
        offer(OP_UNUSED, CNT_W'(5));
        offer(OP_ENQ, '0);
        offer(OP_ENQ, CNT_W'(CNT_MAX));
        offer(OP_ENQ, CNT_W'(1));
        offer(OP_DEQ, '0);
        offer(OP_DEQ, '0);
        offer(OP_CLEAR, '0);
        offer(OP_DEQ, '0);

        // partial batches and overwrite on a two-slot ring
        write_reg(CFG_BATCH_FRAMES, CFG_W'(5));
        write_reg(CFG_SLOT_COUNT, CFG_W'(2));
        offer(OP_ENQ, CNT_W'(3));
        offer(OP_ENQ, CNT_W'(9));
        offer(OP_ENQ, CNT_W'(3));
        offer(OP_ENQ, CNT_W'(5));
        offer(OP_ENQ, CNT_W'(MAX_FRAMES_PER_ITEM));
        offer(OP_DEQ, '0);
        offer(OP_DEQ, '0);
        offer(OP_DEQ, '0);
        offer(OP_ENQ, CNT_W'(2));
        offer(OP_CLEAR, '0);

        // back-pressure: long result hold-off while full-size enqueues keep coming
        write_reg(CFG_BATCH_FRAMES, CFG_W'(1));
        write_reg(CFG_SLOT_COUNT, CFG_W'(MAX_SLOTS));
        @(negedge clk);
        hold_go = !hold_go;
        repeat (12) offer(OP_ENQ, CNT_W'(MAX_FRAMES_PER_ITEM));
        offer(OP_DEQ, '0);
        offer(OP_DEQ, '0);

        for (int s = 0; s < N_SETS; s++)
        begin
            write_reg(CFG_SPARE_A, CFG_W'($urandom_range(CNT_MAX)));
            write_reg(CFG_BATCH_FRAMES, CFG_W'(batch_raw[s]));
            write_reg(CFG_SLOT_COUNT, CFG_W'(slot_raw[s]));
            write_reg(CFG_SPARE_B, CFG_W'($urandom_range(CNT_MAX)));
            send_idle_pct  = idle_tx[s % 4];
            recv_stall_pct = idle_rx[s % 4];
            done = 0;
            while (done < ITEMS_PER_SET)
            begin
                random_item(counted);
                if (counted)
                    done++;
            end
        end

        drain();
        repeat (20) @(negedge clk);
        if (failures == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
